// File: src/gme_pkg.sv
// ----------------------------------------------------------------------------
// gme_pkg: shared types, constants and helpers for the morphology block
// Pixel type, line store geometry, register indexes, min/max selection.
// ----------------------------------------------------------------------------
package gme_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HALF   = 7;
    localparam int PIXEL_BITS = 16;
    localparam int MAX_HEIGHT = 1024;
    localparam int STORE_ROWS = 2 * MAX_HALF + 1;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int BANK_BITS  = $clog2(STORE_ROWS);
    localparam int HALF_BITS  = $clog2(MAX_HALF + 1);
    localparam int SIZE_BITS  = 11;

    typedef logic signed [PIXEL_BITS-1:0] t_pix;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_HALF_WINDOW   = 3'd2,
        REG_OP_SELECT     = 3'd3,
        REG_ELEMENT_SHAPE = 3'd4
    } t_reg_idx;

    localparam logic OP_ERODE  = 1'b0;
    localparam logic OP_DILATE = 1'b1;

    // Pipeline side info that travels with each accepted pixel
    typedef struct packed {
        logic                valid;
        logic                emit;
        logic                zero;
        logic                last;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } t_meta;

    // Neutral element of the reduction: largest value for min, smallest for max
    function automatic t_pix ident(input logic op);
        t_pix v;
        v = (op == OP_DILATE) ? {1'b1, {(PIXEL_BITS-1){1'b0}}}
                              : {1'b0, {(PIXEL_BITS-1){1'b1}}};
        return v;
    endfunction

    function automatic t_pix pick(input t_pix a, input t_pix b, input logic op);
        t_pix v;
        if (op == OP_DILATE) v = (a > b) ? a : b;
        else                 v = (a < b) ? a : b;
        return v;
    endfunction

endpackage

// File: src/gray_morph_erode_dilate.sv
// ----------------------------------------------------------------------------
// gray_morph_erode_dilate: streaming grayscale erosion / dilation
// Raster pixels in, min or max over a square or corner-trimmed element out.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s (pix)  | in  | i_s_tvalid/o_s_tready  | tdata[15:0] pixel_value, tuser frame_start
//  m (res)  | out | o_m_tvalid/i_m_tready  | tdata row/col/value, tlast frame_done
//  cfg      | in  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One pixel per clock sustained while results are taken; a result passes the
//  stage 1, cell chain, stage 3 and output registers after its pixel transfer.
//  The pipeline is set by the line store read, two vertical compare stages,
//  the column cell chain and two horizontal compare stages.
//  Synchronous active-low reset clears position, config and valid bits; the
//  line store is not cleared (unwritten entries are never needed in a frame).
//  The whole pipeline stalls only while a result is held and not taken.
// ----------------------------------------------------------------------------
module gray_morph_erode_dilate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] pixel_value
    input  logic        i_s_tuser,   // [0] frame_start
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [9:0] out_row, [19:10] out_col, [35:20] out_value
    output logic        o_m_tlast,   // frame_done
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import gme_pkg::*;

    localparam int GROUPS = (STORE_ROWS + 3) / 4;

    // ---------------- configuration registers ----------------
    logic [SIZE_BITS-1:0] r_width, r_height;
    logic [HALF_BITS-1:0] r_half;
    logic                 r_op, r_shape;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_BITS'(MAX_WIDTH);
            r_height <= SIZE_BITS'(MAX_HEIGHT);
            r_half   <= HALF_BITS'(1);
            r_op     <= OP_ERODE;
            r_shape  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:   r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT:  r_height <= i_cfg_data;
                REG_HALF_WINDOW:   r_half   <= i_cfg_data[HALF_BITS-1:0];
                REG_OP_SELECT:     r_op     <= i_cfg_data[0];
                REG_ELEMENT_SHAPE: r_shape  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, above range saturates
    logic [SIZE_BITS-1:0] w_eff, h_eff;
    logic [BANK_BITS-1:0] span;      // 2h
    logic                 trim;      // corners removed

    assign w_eff = (r_width == '0) ? SIZE_BITS'(1) :
                   (r_width > SIZE_BITS'(MAX_WIDTH)) ? SIZE_BITS'(MAX_WIDTH) : r_width;
    assign h_eff = (r_height == '0) ? SIZE_BITS'(1) :
                   (r_height > SIZE_BITS'(MAX_HEIGHT)) ? SIZE_BITS'(MAX_HEIGHT) : r_height;
    assign span  = {r_half, 1'b0};
    assign trim  = r_shape && (r_half != '0);

    // Global advance: move when the output register is free or being drained
    logic en, acc;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;

    // ---------------- stage 0: position counters ----------------
    logic [ROW_BITS-1:0]  r_row_cnt, n_row_cnt;
    logic [COL_BITS-1:0]  r_col_cnt, n_col_cnt;
    logic [BANK_BITS-1:0] r_bank,    n_bank;
    logic [SIZE_BITS-1:0] rc, cc;    // position of this pixel
    logic [BANK_BITS-1:0] bk;
    logic [SIZE_BITS-1:0] hw, ii, jj;
    t_meta                m0;

    always_comb begin
        rc = i_s_tuser ? '0 : SIZE_BITS'(r_row_cnt);
        cc = i_s_tuser ? '0 : SIZE_BITS'(r_col_cnt);
        bk = i_s_tuser ? '0 : r_bank;
        if (cc >= w_eff) begin
            cc = '0;
            rc = rc + 1'b1;
            bk = (bk == BANK_BITS'(STORE_ROWS - 1)) ? '0 : bk + 1'b1;
        end
        if (rc >= h_eff) begin
            rc = '0;
            bk = '0;
        end
        hw = SIZE_BITS'(r_half);
        ii = rc - hw;
        jj = cc - hw;
        m0.valid = 1'b1;
        m0.emit  = (rc >= hw) && (cc >= hw);
        m0.zero  = (ii < hw + 1'b1) || (jj < hw + 1'b1) ||
                   (ii + hw + 1'b1 >= h_eff) || (jj + hw + 1'b1 >= w_eff);
        m0.last  = (rc == h_eff - 1'b1) && (cc == w_eff - 1'b1);
        m0.row   = ii[ROW_BITS-1:0];
        m0.col   = jj[COL_BITS-1:0];
        if (cc + 1'b1 >= w_eff) begin
            n_col_cnt = '0;
            if (rc + 1'b1 >= h_eff) begin
                n_row_cnt = '0;
                n_bank    = '0;
            end else begin
                n_row_cnt = rc[ROW_BITS-1:0] + 1'b1;
                n_bank    = (bk == BANK_BITS'(STORE_ROWS - 1)) ? '0 : bk + 1'b1;
            end
        end else begin
            n_col_cnt = cc[COL_BITS-1:0] + 1'b1;
            n_row_cnt = rc[ROW_BITS-1:0];
            n_bank    = bk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_bank    <= '0;
        end else if (acc) begin
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
            r_bank    <= n_bank;
        end
    end

    // ---------------- line store ----------------
    t_pix rd_data [STORE_ROWS];

    gme_line_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (acc),
        .i_wr_bank (bk),
        .i_addr    (cc[COL_BITS-1:0]),
        .i_wr_data (t_pix'(i_s_tdata)),
        .i_rd_en   (en),
        .o_rd_data (rd_data)
    );

    // ---------------- stage 1: taps and first vertical level ----------------
    t_meta                r_m1, r_m2, r_m3, r_m4;
    t_pix                 r_pix1;
    logic [BANK_BITS-1:0] r_bank1;
    t_pix                 r_vf [GROUPS];
    t_pix                 r_vi [GROUPS];
    t_pix                 vf_g [GROUPS];
    t_pix                 vi_g [GROUPS];

    // Tap k is row r-k; tap 0 is the pixel just taken
    always_comb begin
        t_pix                 tap;
        t_pix                 tf, ti;
        logic [BANK_BITS-1:0] b;
        for (int g = 0; g < GROUPS; g++) begin
            vf_g[g] = ident(r_op);
            vi_g[g] = ident(r_op);
        end
        for (int k = 0; k < STORE_ROWS; k++) begin
            b = (r_bank1 >= BANK_BITS'(k)) ? r_bank1 - BANK_BITS'(k)
                                          : r_bank1 + BANK_BITS'(STORE_ROWS - k);
            tap = (k == 0) ? r_pix1 : rd_data[b];
            tf  = (BANK_BITS'(k) <= span) ? tap : ident(r_op);
            ti  = (k >= 1 && BANK_BITS'(k) < span) ? tap : ident(r_op);
            vf_g[k/4] = pick(vf_g[k/4], tf, r_op);
            vi_g[k/4] = pick(vi_g[k/4], ti, r_op);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1.valid <= 1'b0;
            r_m2.valid <= 1'b0;
            r_m3.valid <= 1'b0;
            r_m4.valid <= 1'b0;
        end else if (en) begin
            r_m1.valid <= acc;
            r_m2.valid <= r_m1.valid;
            r_m3.valid <= r_m2.valid;
            r_m4.valid <= r_m3.valid;
        end
        if (en) begin
            {r_m1.emit, r_m1.zero, r_m1.last, r_m1.row, r_m1.col} <=
                {m0.emit, m0.zero, m0.last, m0.row, m0.col};
            {r_m2.emit, r_m2.zero, r_m2.last, r_m2.row, r_m2.col} <=
                {r_m1.emit, r_m1.zero, r_m1.last, r_m1.row, r_m1.col};
            {r_m3.emit, r_m3.zero, r_m3.last, r_m3.row, r_m3.col} <=
                {r_m2.emit, r_m2.zero, r_m2.last, r_m2.row, r_m2.col};
            {r_m4.emit, r_m4.zero, r_m4.last, r_m4.row, r_m4.col} <=
                {r_m3.emit, r_m3.zero, r_m3.last, r_m3.row, r_m3.col};
            r_pix1  <= t_pix'(i_s_tdata);
            r_bank1 <= bk;
            r_vf    <= vf_g;
            r_vi    <= vi_g;
        end
    end

    // ---------------- stage 2: vertical finish into the cell chain ----------------
    t_pix col_full, col_inner;

    always_comb begin
        col_full  = ident(r_op);
        col_inner = ident(r_op);
        for (int g = 0; g < GROUPS; g++) begin
            col_full  = pick(col_full,  r_vf[g], r_op);
            col_inner = pick(col_inner, r_vi[g], r_op);
        end
        if (!trim) col_inner = col_full;
    end

    // Cell 0 holds the newest column (c), cell m holds column c-m
    t_pix cell_full  [STORE_ROWS];
    t_pix cell_inner [STORE_ROWS];
    logic shift;
    assign shift = en && r_m2.valid;

    for (genvar m = 0; m < STORE_ROWS; m++) begin : g_cell
        if (m == 0) begin : g_head
            gme_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_full  (col_full),
                .i_inner (col_inner),
                .o_full  (cell_full[m]),
                .o_inner (cell_inner[m])
            );
        end else begin : g_body
            gme_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_full  (cell_full[m-1]),
                .i_inner (cell_inner[m-1]),
                .o_full  (cell_full[m]),
                .o_inner (cell_inner[m])
            );
        end
    end

    // ---------------- stage 3: horizontal partials ----------------
    t_pix hz_g [GROUPS];
    t_pix r_hz [GROUPS];

    always_comb begin
        t_pix v;
        for (int g = 0; g < GROUPS; g++) hz_g[g] = ident(r_op);
        for (int m = 0; m < STORE_ROWS; m++) begin
            // edge columns of the element take the trimmed column value
            v = (m == 0 || BANK_BITS'(m) == span) ? cell_inner[m] : cell_full[m];
            if (BANK_BITS'(m) > span) v = ident(r_op);
            hz_g[m/4] = pick(hz_g[m/4], v, r_op);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_hz <= hz_g;
    end

    // ---------------- stage 4: final reduce, border, output register ----------------
    t_pix res;

    always_comb begin
        res = ident(r_op);
        for (int g = 0; g < GROUPS; g++) res = pick(res, r_hz[g], r_op);
        if (r_m4.zero) res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (en) begin
            o_m_tvalid <= r_m4.valid && r_m4.emit;
        end
        if (en) begin
            o_m_tdata <= {4'b0, res, r_m4.col, r_m4.row};
            o_m_tlast <= r_m4.last;
        end
    end

endmodule

// File: src/gme_line_store.sv
// ----------------------------------------------------------------------------
// gme_line_store: banked line store, one bank per image row modulo depth
// One write per cycle into the bank of the current row; every bank read at
// the current column, read data registered.
// ----------------------------------------------------------------------------
module gme_line_store (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [gme_pkg::BANK_BITS-1:0] i_wr_bank,
    input  logic [gme_pkg::COL_BITS-1:0]  i_addr,
    input  gme_pkg::t_pix                 i_wr_data,
    input  logic                          i_rd_en,
    output gme_pkg::t_pix                 o_rd_data [gme_pkg::STORE_ROWS]
);
    import gme_pkg::*;

    for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
        t_pix r_mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_bank == BANK_BITS'(b))) begin
                r_mem[i_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                o_rd_data[b] <= r_mem[i_addr];
            end
        end
    end

endmodule

// File: src/gme_cell.sv
// ----------------------------------------------------------------------------
// gme_cell: one column slot of the horizontal window chain
// Holds the full and corner-trimmed vertical reductions of one column and
// hands them to the next older slot on every pixel transfer.
// ----------------------------------------------------------------------------
module gme_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  gme_pkg::t_pix i_full,
    input  gme_pkg::t_pix i_inner,
    output gme_pkg::t_pix o_full,
    output gme_pkg::t_pix o_inner
);
    import gme_pkg::*;

    t_pix r_full;
    t_pix r_inner;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_full  <= i_full;
            r_inner <= i_inner;
        end
    end

    assign o_full  = r_full;
    assign o_inner = r_inner;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for gray_morph_erode_dilate
// Frames of signed pixels are streamed in, each result transfer is checked
// against a behavioral erosion/dilation model, and registers change between
// frames only.
// ----------------------------------------------------------------------------
module tb_top;
    import gme_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct {
        logic [15:0] value;
        logic        fstart;
    } t_pix_item;

    typedef struct {
        logic [9:0]  row;
        logic [9:0]  col;
        logic [15:0] value;
        logic        done;
    } t_result;

    // DUT ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        o_s_tready;
    logic [15:0] s_data      = '0;
    logic        s_user      = 1'b0;
    logic        o_m_tvalid;
    logic        m_ready     = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic        cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  cfg_index   = '0;
    logic [10:0] cfg_data    = '0;

    gray_morph_erode_dilate uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_pix_item pixel_queue[$];
    t_result   result_queue[$];
    int        errors     = 0;
    int        idle_mode  = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    int        sent_items = 0;   // pixels queued so far

    // ---- model state ------------------------------------------------------
    logic signed [15:0] rows_mem [STORE_ROWS][MAX_WIDTH];
    int unsigned pos_row = 0, pos_col = 0;
    int unsigned reg_width = 1024, reg_height = 1024, reg_half = 1;
    logic        reg_dilate = OP_ERODE, reg_rounded = 1'b1;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    // Advance the raster position by one pixel and queue the result it makes.
    task automatic morph_pixel(input logic [15:0] raw, input logic fstart);
        int unsigned w, ht, hw, r, c, i, j, span, dk, dl;
        logic signed [15:0] acc, v;
        t_result res;
        w  = (reg_width == 0) ? 1 : ((reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width);
        ht = (reg_height == 0) ? 1 : ((reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height);
        hw = (reg_half > MAX_HALF) ? MAX_HALF : reg_half;
        if (fstart) begin
            pos_row = 0;
            pos_col = 0;
        end
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= ht) pos_row = 0;
        r = pos_row;
        c = pos_col;
        rows_mem[r % STORE_ROWS][c] = raw;
        if (r >= hw && c >= hw) begin
            i = r - hw;
            j = c - hw;
            acc = 0;
            // border band stays zero
            if (!(i < hw + 1 || j < hw + 1 || i + hw + 1 >= ht || j + hw + 1 >= w)) begin
                span = 2 * hw;
                acc = rows_mem[i % STORE_ROWS][j];
                for (dk = 0; dk <= span; dk++) begin
                    for (dl = 0; dl <= span; dl++) begin
                        // rounded element drops the four corners
                        if (!(reg_rounded && hw > 0 && (dk == 0 || dk == span)
                              && (dl == 0 || dl == span))) begin
                            v = rows_mem[(r - span + dk) % STORE_ROWS][c - span + dl];
                            if (reg_dilate ? (v > acc) : (v < acc)) acc = v;
                        end
                    end
                end
            end
            res.row   = i[9:0];
            res.col   = j[9:0];
            res.value = acc;
            res.done  = (r == ht - 1 && c == w - 1);
            result_queue.push_back(res);
        end
        if (c + 1 >= w) begin
            pos_col = 0;
            pos_row = (r + 1 >= ht) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endtask

    // ---- pixel driver: holds tvalid until the transfer, then loads next ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || o_s_tready) begin
            if (s_valid) morph_pixel(s_data, s_user);
            if (pixel_queue.size() > 0 &&
                !((idle_mode == 1 && $urandom_range(99) < 69) ||
                  (idle_mode == 3 && $urandom_range(99) < 18))) begin
                s_valid <= 1'b1;
                s_data  <= pixel_queue[0].value;
                s_user  <= pixel_queue[0].fstart;
                void'(pixel_queue.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---- result monitor and receiver back-pressure ------------------------
    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                if (result_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata=%h", o_m_tdata));
                end else begin
                    exp_res = result_queue.pop_front();
                    if (o_m_tdata[9:0] !== exp_res.row)
                        report_mismatch($sformatf("row %0d, want %0d",
                                        o_m_tdata[9:0], exp_res.row));
                    if (o_m_tdata[19:10] !== exp_res.col)
                        report_mismatch($sformatf("col %0d, want %0d",
                                        o_m_tdata[19:10], exp_res.col));
                    if (o_m_tdata[35:20] !== exp_res.value)
                        report_mismatch($sformatf("value %h, want %h at (%0d,%0d)",
                                        o_m_tdata[35:20], exp_res.value,
                                        exp_res.row, exp_res.col));
                    if (o_m_tlast !== exp_res.done)
                        report_mismatch($sformatf("frame_done %b, want %b",
                                        o_m_tlast, exp_res.done));
                end
            end
            m_ready <= !((idle_mode == 2 && $urandom_range(99) < 69) ||
                         (idle_mode == 3 && $urandom_range(99) < 18));
        end
    end

    // ---- watchdog: cycles without any transfer ----------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** gray_morph_erode_dilate: FAILED **");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---- stimulus -----------------------------------------------------------
    task automatic wait_idle();
        while (pixel_queue.size() > 0 || s_valid || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [10:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   reg_width   = 32'(val);
            REG_IMAGE_HEIGHT:  reg_height  = 32'(val);
            REG_HALF_WINDOW:   reg_half    = 32'(val[2:0]);
            REG_OP_SELECT:     reg_dilate  = val[0];
            REG_ELEMENT_SHAPE: reg_rounded = val[0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_pixel(input int flavor);
        case (flavor)
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(6)) - 16'd3;   // many ties
        endcase
    endfunction

    // Program the block for one frame, then queue it. A restart point > 0
    // puts a stray frame start mid-stream; a full frame follows it.
    task automatic run_frame(input int w, input int ht, input int hw, input logic op,
                             input logic shape, input bit fs_first, input int restart);
        int n, k, flavor, ew, eh;
        t_pix_item it;
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 11'(w));
        write_reg(REG_IMAGE_HEIGHT, 11'(ht));
        write_reg(REG_HALF_WINDOW, 11'(hw));
        write_reg(REG_OP_SELECT, 11'(op));
        write_reg(REG_ELEMENT_SHAPE, 11'(shape));
        ew = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        eh = (ht == 0) ? 1 : ((ht > MAX_HEIGHT) ? MAX_HEIGHT : ht);
        n = ew * eh + restart;
        flavor = $urandom_range(3);
        for (k = 0; k < n; k++) begin
            it.value  = rand_pixel(flavor);
            it.fstart = (k == 0 && (fs_first || restart > 0)) || (restart > 0 && k == restart);
            pixel_queue.push_back(it);
        end
        sent_items += n;
    endtask

    initial begin
        int fw, fh, frame_no;
        bit clean;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        run_frame(6, 6, 1, OP_ERODE, 1'b0, 1'b1, 0);
        run_frame(6, 5, 1, OP_DILATE, 1'b1, 1'b1, 0);
        run_frame(0, 3, 0, OP_DILATE, 1'b1, 1'b1, 0);       // zero width taken as 1
        run_frame(4, 0, 0, OP_ERODE, 1'b0, 1'b1, 0);        // zero height taken as 1
        run_frame(3, 3, 2, OP_ERODE, 1'b1, 1'b1, 0);        // image below element size
        run_frame(5, 5, 0, OP_ERODE, 1'b1, 1'b1, 0);        // centre-only element
        run_frame(16, 16, 7, OP_DILATE, 1'b0, 1'b1, 0);     // largest element

        frame_no = 0;
        clean = 1;
        while (sent_items < 1450) begin
            idle_mode = frame_no % 4;
            frame_no++;
            if ($urandom_range(9) == 0) begin
                fw = $urandom_range(40, 1);
                fh = $urandom_range(6, 1);
            end else begin
                fw = $urandom_range(14, 1);
                fh = $urandom_range(14, 1);
            end
            if ($urandom_range(9) == 0) begin
                run_frame(fw, fh, $urandom_range(7), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'b1, $urandom_range(fw * fh, 1));
            end else begin
                // a frame may follow a complete one without a frame start
                run_frame(fw, fh, ($urandom_range(3) == 0) ? $urandom_range(7)
                                                           : $urandom_range(3),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          !(clean && $urandom_range(3) == 0), 0);
            end
        end
        wait_idle();
        if (errors == 0)
            $display("** gray_morph_erode_dilate: PASSED **");
        else
            $display("** gray_morph_erode_dilate: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
src/gme_pkg.sv
src/gme_line_store.sv
src/gme_cell.sv
src/gray_morph_erode_dilate.sv
test/tb_top.sv
